[src/mrsm_pkg.sv]
package mrsm_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int ADDR_W      = 64;
	localparam int TYPE_W      = 3;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] len;
		logic [TYPE_W-1:0] kind;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_GT  = 2'd2
	} alu_op_t;

endpackage

[src/mrsm_in_if.sv]
interface mrsm_in_if import mrsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] entry_addr;
	logic [ADDR_W-1:0] entry_length;
	logic [TYPE_W-1:0] entry_type;
	logic              final_entry;

	modport source (output valid, entry_addr, entry_length, entry_type, final_entry,
		input ready);
	modport sink (input valid, entry_addr, entry_length, entry_type, final_entry,
		output ready);
endinterface

[src/mrsm_out_if.sv]
interface mrsm_out_if import mrsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] region_addr;
	logic [ADDR_W-1:0] region_size;
	logic [TYPE_W-1:0] region_type;
	logic              last_region;
	logic              overflowed;

	modport source (output valid, region_addr, region_size, region_type, last_region,
		overflowed, input ready);
	modport sink (input valid, region_addr, region_size, region_type, last_region,
		overflowed, output ready);
endinterface

[src/memory_region_sort_merge.sv]
// Channel  Role    Payload                                                Handshake
// entry    sink    entry_addr, entry_length, entry_type, final_entry      valid/ready
// region   source  region_addr, region_size, region_type, last_region,    valid/ready
//                  overflowed
//
// A non-final item passes through the accept and store states. A full table first
// runs an insertion sort and a merge; the final item runs the same pair, then each
// region passes through read, load and output states and waits on region.ready.
// The table's one read and one write port and the one shared 64-bit adder set this
// sequencing. entry.ready is high only while idle.
// Reset clears the sequencer, entry count and overflow flag; the table is not cleared.
module memory_region_sort_merge import mrsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mrsm_in_if.sink    entry,
	mrsm_out_if.source region
);

	typedef enum logic [15:0] {
		ST_IDLE     = 16'h0001,
		ST_STORE    = 16'h0002,
		ST_SORT_I   = 16'h0004,
		ST_SORT_KEY = 16'h0008,
		ST_SORT_RD  = 16'h0010,
		ST_SORT_CMP = 16'h0020,
		ST_MG_START = 16'h0040,
		ST_MG_FIRST = 16'h0080,
		ST_MG_NEXT  = 16'h0100,
		ST_MG_LOAD  = 16'h0200,
		ST_MG_CMP1  = 16'h0400,
		ST_MG_CMP2  = 16'h0800,
		ST_MG_EXT   = 16'h1000,
		ST_EMIT_RD  = 16'h2000,
		ST_EMIT_LD  = 16'h4000,
		ST_EMIT_OUT = 16'h8000
	} state_t;

	typedef struct packed {
		slot_t slot;
		logic  last;
		logic  ovf;
	} out_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic              compact_q;

	logic [CNT_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [CNT_W-1:0]  r_q;
	logic [IDX_W-1:0]  w_q;
	logic [IDX_W-1:0]  k_q;
	slot_t             new_q;
	logic              final_q;
	slot_t             key_q;
	slot_t             run_q;
	logic [ADDR_W-1:0] run_end_q;
	logic [ADDR_W-1:0] cur_end_q;
	out_t              out_q;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	slot_t             wdata;
	logic [IDX_W-1:0]  raddr;
	logic [SLOT_W-1:0] rdata_raw;
	slot_t             rdata;

	alu_op_t           alu_op;
	logic [ADDR_W-1:0] alu_a;
	logic [ADDR_W-1:0] alu_b;
	logic [ADDR_W-1:0] alu_res;
	logic              alu_flag;

	logic              full;
	logic              fits;
	logic              k_last;

	assign rdata  = slot_t'(rdata_raw);
	assign full   = (count_q == CNT_W'(MAX_ENTRIES));
	assign fits   = ~alu_flag && (key_q.kind == run_q.kind);
	assign k_last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

	mrsm_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	mrsm_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.flag(alu_flag)
	);

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = rdata.base;
		alu_b  = rdata.len;
		case (state_q)
			ST_SORT_CMP: begin
				alu_op = ALU_GT;
				alu_a  = rdata.base;
				alu_b  = key_q.base;
			end
			ST_MG_CMP1: begin
				alu_op = ALU_GT;
				alu_a  = key_q.base;
				alu_b  = run_end_q;
			end
			ST_MG_CMP2: begin
				alu_op = ALU_GT;
				alu_a  = cur_end_q;
				alu_b  = run_end_q;
			end
			ST_MG_EXT: begin
				alu_op = ALU_SUB;
				alu_a  = cur_end_q;
				alu_b  = run_q.base;
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	// table port steering
	always_comb begin
		we    = 1'b0;
		waddr = j_q;
		wdata = key_q;
		raddr = '0;
		case (state_q)
			ST_STORE: begin
				we    = ~full;
				waddr = count_q[IDX_W-1:0];
				wdata = new_q;
			end
			ST_SORT_I: begin
				raddr = i_q[IDX_W-1:0];
			end
			ST_SORT_RD: begin
				we    = (j_q == '0);
				raddr = j_q - IDX_W'(1);
			end
			ST_SORT_CMP: begin
				we    = 1'b1;
				wdata = alu_flag ? rdata : key_q;
			end
			ST_MG_NEXT: begin
				we    = (r_q >= count_q);
				waddr = w_q;
				wdata = run_q;
				raddr = r_q[IDX_W-1:0];
			end
			ST_MG_CMP1: begin
				we    = ~fits;
				waddr = w_q;
				wdata = run_q;
			end
			ST_EMIT_RD: begin
				raddr = k_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			compact_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (entry.valid) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (full && !compact_q) begin
						compact_q <= 1'b1;
						state_q   <= ST_SORT_I;
					end else begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						compact_q <= 1'b0;
						state_q   <= final_q ? ST_SORT_I : ST_IDLE;
					end
				end
				ST_SORT_I: begin
					state_q <= (i_q >= count_q) ? ST_MG_START : ST_SORT_KEY;
				end
				ST_SORT_KEY: begin
					state_q <= ST_SORT_RD;
				end
				ST_SORT_RD: begin
					state_q <= (j_q == '0) ? ST_SORT_I : ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					state_q <= alu_flag ? ST_SORT_RD : ST_SORT_I;
				end
				ST_MG_START: begin
					state_q <= ST_MG_FIRST;
				end
				ST_MG_FIRST: begin
					state_q <= ST_MG_NEXT;
				end
				ST_MG_NEXT: begin
					if (r_q >= count_q) begin
						count_q <= CNT_W'(w_q) + CNT_W'(1);
						state_q <= compact_q ? ST_STORE : ST_EMIT_RD;
					end else begin
						state_q <= ST_MG_LOAD;
					end
				end
				ST_MG_LOAD: begin
					state_q <= ST_MG_CMP1;
				end
				ST_MG_CMP1: begin
					state_q <= fits ? ST_MG_CMP2 : ST_MG_NEXT;
				end
				ST_MG_CMP2: begin
					state_q <= alu_flag ? ST_MG_EXT : ST_MG_NEXT;
				end
				ST_MG_EXT: begin
					state_q <= ST_MG_NEXT;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (region.ready) begin
						if (out_q.last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				new_q   <= '{base: entry.entry_addr, len: entry.entry_length,
					kind: entry.entry_type};
				final_q <= entry.final_entry;
				i_q     <= CNT_W'(1);
			end
			ST_STORE: begin
				i_q <= CNT_W'(1);
			end
			ST_SORT_KEY: begin
				key_q <= rdata;
				j_q   <= i_q[IDX_W-1:0];
			end
			ST_SORT_RD: begin
				if (j_q == '0) begin
					i_q <= i_q + CNT_W'(1);
				end
			end
			ST_SORT_CMP: begin
				if (alu_flag) begin
					j_q <= j_q - IDX_W'(1);
				end else begin
					i_q <= i_q + CNT_W'(1);
				end
			end
			ST_MG_START: begin
				w_q <= '0;
				r_q <= CNT_W'(1);
			end
			ST_MG_FIRST: begin
				run_q     <= rdata;
				run_end_q <= alu_res;
			end
			ST_MG_NEXT: begin
				k_q <= '0;
			end
			ST_MG_LOAD: begin
				key_q     <= rdata;
				cur_end_q <= alu_res;
			end
			ST_MG_CMP1: begin
				// open a new region unless the candidate touches the running one and has its type
				if (!fits) begin
					w_q       <= w_q + IDX_W'(1);
					run_q     <= key_q;
					run_end_q <= cur_end_q;
					r_q       <= r_q + CNT_W'(1);
				end
			end
			ST_MG_CMP2: begin
				if (alu_flag) begin
					run_end_q <= cur_end_q;
				end else begin
					r_q <= r_q + CNT_W'(1);
				end
			end
			ST_MG_EXT: begin
				run_q.len <= alu_res;
				r_q       <= r_q + CNT_W'(1);
			end
			ST_EMIT_LD: begin
				out_q <= '{slot: rdata, last: k_last, ovf: ovf_q};
			end
			ST_EMIT_OUT: begin
				if (region.ready) begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			default: begin
				final_q <= final_q;
			end
		endcase
	end

	assign entry.ready        = (state_q == ST_IDLE);
	assign region.valid       = (state_q == ST_EMIT_OUT);
	assign region.region_addr = out_q.slot.base;
	assign region.region_size = out_q.slot.len;
	assign region.region_type = out_q.slot.kind;
	assign region.last_region = out_q.last;
	assign region.overflowed  = out_q.ovf;

endmodule

[src/mrsm_ram.sv]
module mrsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/mrsm_alu.sv]
module mrsm_alu import mrsm_pkg::*; (
	input  alu_op_t           op,
	input  logic [ADDR_W-1:0] a,
	input  logic [ADDR_W-1:0] b,
	output logic [ADDR_W-1:0] res,
	output logic              flag
);

	logic [ADDR_W-1:0] opx;
	logic [ADDR_W-1:0] opy;
	logic              cin;
	logic [ADDR_W:0]   sum;

	// a > b is taken from the borrow of b - a
	always_comb begin
		case (op)
			ALU_ADD: begin
				opx = a;
				opy = b;
				cin = 1'b0;
			end
			ALU_SUB: begin
				opx = a;
				opy = ~b;
				cin = 1'b1;
			end
			ALU_GT: begin
				opx = b;
				opy = ~a;
				cin = 1'b1;
			end
			default: begin
				opx = a;
				opy = b;
				cin = 1'b0;
			end
		endcase
	end

	assign sum  = {1'b0, opx} + {1'b0, opy} + {{ADDR_W{1'b0}}, cin};
	assign res  = sum[ADDR_W-1:0];
	assign flag = ~sum[ADDR_W];

endmodule
